// ===== rtl/wgc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the weighted group collapse block.
package wgc_pkg;

    // Field and accumulator widths
    localparam int VALUE_W   = 32;
    localparam int WEIGHT_W  = 32;
    localparam int WSUM_W    = 64;
    localparam int WTSUM_W   = 48;
    localparam int RESULT_W  = 48;
    localparam int FRAC_BITS_DEFAULT = 16;

    // Stream packing widths
    localparam int S_TDATA_W = VALUE_W + WEIGHT_W;
    localparam int M_TDATA_W = RESULT_W;
    localparam int M_TUSER_W = 2;

    // Divider step counter
    localparam int DIV_STEPS = WSUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Result clamp limits, held as 64-bit magnitudes
    localparam logic [WSUM_W-1:0] RES_POS_MAX = {{(WSUM_W-RESULT_W+1){1'b0}},
                                                 {(RESULT_W-1){1'b1}}};
    localparam logic [WSUM_W-1:0] RES_NEG_MAG = {{(WSUM_W-RESULT_W){1'b0}}, 1'b1,
                                                 {(RESULT_W-1){1'b0}}};

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CLOSE,
        ST_DIV,
        ST_FIN
    } wgc_state_t;

    // Accumulator control from the sequencer
    typedef struct packed {
        logic mul_en;
        logic add_en;
        logic clear;
    } wgc_acc_ctl_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } wgc_div_sts_t;

endpackage

// ===== rtl/wgc_accum.sv =====
`timescale 1ns / 1ps
// Sample multiplier and saturating weight / weighted-value accumulators.
module wgc_accum (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wgc_pkg::wgc_acc_ctl_t             ctl,
    input  logic signed [wgc_pkg::VALUE_W-1:0] sample_value,
    input  logic [wgc_pkg::WEIGHT_W-1:0]      sample_weight,
    output logic signed [wgc_pkg::WSUM_W-1:0] weighted_sum,
    output logic [wgc_pkg::WTSUM_W-1:0]       weight_sum,
    output logic                              clip_seen
);
    import wgc_pkg::*;

    logic signed [WSUM_W:0]   product_full;
    logic signed [WSUM_W-1:0] product_reg, product_next;
    logic signed [WSUM_W-1:0] wsum_reg, wsum_next;
    logic [WTSUM_W-1:0]       wtsum_reg, wtsum_next;
    logic                     clip_reg, clip_next;
    logic [WSUM_W:0]          wsum_add;
    logic [WTSUM_W:0]         wtsum_add;
    logic                     wsum_ovf, wtsum_ovf;

    // Signed value times unsigned weight; the product always fits 64 bits
    assign product_full = sample_value * $signed({1'b0, sample_weight});
    assign product_next = ctl.mul_en ? product_full[WSUM_W-1:0] : product_reg;

    // Sign-extended (weighted sum) and zero-extended (weight sum) adds expose overflow in the extra bit
    assign wsum_add  = {wsum_reg[WSUM_W-1], wsum_reg} +
                       {product_reg[WSUM_W-1], product_reg};
    assign wsum_ovf  = wsum_add[WSUM_W] != wsum_add[WSUM_W-1];
    assign wtsum_add = {1'b0, wtsum_reg} +
                       {{(WTSUM_W-WEIGHT_W+1){1'b0}}, sample_weight};
    assign wtsum_ovf = wtsum_add[WTSUM_W];

    // Add one product and weight with clamping, or clear at group end
    always_comb begin
        wsum_next  = wsum_reg;
        wtsum_next = wtsum_reg;
        clip_next  = clip_reg;
        if (ctl.clear) begin
            wsum_next  = '0;
            wtsum_next = '0;
            clip_next  = 1'b0;
        end else if (ctl.add_en) begin
            if (wsum_ovf) begin
                wsum_next = wsum_add[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}}
                                             : {1'b0, {(WSUM_W-1){1'b1}}};
            end else begin
                wsum_next = wsum_add[WSUM_W-1:0];
            end
            wtsum_next = wtsum_ovf ? {WTSUM_W{1'b1}} : wtsum_add[WTSUM_W-1:0];
            clip_next  = clip_reg | wsum_ovf | wtsum_ovf;
        end
    end

    // Product register needs no reset
    always_ff @(posedge aclk) begin
        product_reg <= product_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsum_reg  <= '0;
            wtsum_reg <= '0;
            clip_reg  <= 1'b0;
        end else begin
            wsum_reg  <= wsum_next;
            wtsum_reg <= wtsum_next;
            clip_reg  <= clip_next;
        end
    end

    assign weighted_sum = wsum_reg;
    assign weight_sum   = wtsum_reg;
    assign clip_seen    = clip_reg;

endmodule

// ===== rtl/wgc_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the group normalization.
module wgc_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [wgc_pkg::WSUM_W-1:0]   dividend,
    input  logic [wgc_pkg::WTSUM_W-1:0]  divisor,
    output logic [wgc_pkg::WSUM_W-1:0]   quotient,
    output wgc_pkg::wgc_div_sts_t        sts
);
    import wgc_pkg::*;

    logic [WSUM_W-1:0]    quot_reg, quot_next;
    logic [WTSUM_W-1:0]   rem_reg, rem_next;
    logic [WTSUM_W-1:0]   dvsr_reg, dvsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WTSUM_W:0]     rem_shift;
    logic [WTSUM_W:0]     rem_diff;
    logic                 qbit;

    // Bring down the next dividend bit and try the subtract
    assign rem_shift = {rem_reg, quot_reg[WSUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvsr_reg};
    assign qbit      = !rem_diff[WTSUM_W];

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quot_next = {quot_reg[WSUM_W-2:0], qbit};
            rem_next  = qbit ? rem_diff[WTSUM_W-1:0] : rem_shift[WTSUM_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = quot_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// ===== rtl/weighted_group_collapse.sv =====
`timescale 1ns / 1ps
// Top level of the weighted group collapse: sequencer, result clamp and output register.
//
// Each input beat carries one fine-group sample (value and weight in s_tdata, has_sample
// in s_tuser) and s_tlast closes the current coarse group. A beat that does not close a
// group passes through the 32x33 multiplier, then through the saturating accumulators,
// and the next beat is taken during the accumulate cycle. Without a divide a closing beat
// holds the input through multiply, accumulate, close, finish and the idle cycle that
// takes the next beat. With normalize set and a nonzero weight sum the shared restoring
// divider runs between close and finish: 64 steps of one quotient bit each, after which
// the quotient is picked up. The finish cycle repeats while the previous result has not
// yet been taken. The result is the weighted sum shifted right by FRAC_BITS, or divided
// by the weight sum, truncated toward zero and clamped to 48 bits signed. The user must
// write normalize (cfg_wdata, reset 1) only while idle; the block does not enforce it.
module weighted_group_collapse #(
    parameter int FRAC_BITS = wgc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: normalize
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    // Sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wgc_pkg::S_TDATA_W-1:0]   s_tdata,  // [31:0] sample_value, [63:32] sample_weight
    input  logic                            s_tuser,  // [0] has_sample
    input  logic                            s_tlast,  // closes_group
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wgc_pkg::M_TDATA_W-1:0]   m_tdata,  // [47:0] group_result
    output logic [wgc_pkg::M_TUSER_W-1:0]   m_tuser   // [0] zero_weight, [1] saturated
);
    import wgc_pkg::*;

    wgc_state_t state_reg, state_next;

    logic                       normalize_reg, normalize_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic [WEIGHT_W-1:0]        weight_reg, weight_next;
    logic                       has_reg, has_next;
    logic                       closes_reg, closes_next;
    logic                       neg_reg, neg_next;
    logic [WSUM_W-1:0]          mag_reg, mag_next;
    logic                       m_valid_reg, m_valid_next;
    logic [RESULT_W-1:0]        m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0]       m_user_reg, m_user_next;

    wgc_acc_ctl_t               acc_ctl;
    wgc_div_sts_t               div_sts;
    logic                       div_start;
    logic [WSUM_W-1:0]          quotient;
    logic signed [WSUM_W-1:0]   weighted_sum;
    logic [WTSUM_W-1:0]         weight_sum;
    logic                       clip_seen;

    logic                       s_accept;
    logic                       out_free;
    logic [WSUM_W-1:0]          sum_mag;
    logic [WSUM_W-1:0]          clamp_mag;
    logic                       clamp_hit;
    logic [RESULT_W-1:0]        result;

    // Shared arithmetic units
    wgc_accum u_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (acc_ctl),
        .sample_value  (value_reg),
        .sample_weight (weight_reg),
        .weighted_sum  (weighted_sum),
        .weight_sum    (weight_sum),
        .clip_seen     (clip_seen)
    );

    wgc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (weight_sum),
        .quotient (quotient),
        .sts      (div_sts)
    );

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Magnitude of the weighted sum; the most negative value maps to 2^63
    assign sum_mag = weighted_sum[WSUM_W-1] ? (~weighted_sum + 1'b1) : weighted_sum;

    // Clamp the magnitude to the signed 48-bit range and restore the sign
    always_comb begin
        clamp_mag = mag_reg;
        clamp_hit = 1'b0;
        if (neg_reg) begin
            if (mag_reg > RES_NEG_MAG) begin
                clamp_mag = RES_NEG_MAG;
                clamp_hit = 1'b1;
            end
        end else if (mag_reg > RES_POS_MAX) begin
            clamp_mag = RES_POS_MAX;
            clamp_hit = 1'b1;
        end
        result = neg_reg ? (~clamp_mag[RESULT_W-1:0] + 1'b1) : clamp_mag[RESULT_W-1:0];
    end

    // Sequencer: next state and unit control
    always_comb begin
        state_next     = state_reg;
        normalize_next = cfg_we ? cfg_wdata : normalize_reg;
        value_next     = value_reg;
        weight_next    = weight_reg;
        has_next       = has_reg;
        closes_next    = closes_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        acc_ctl        = '0;
        div_start      = 1'b0;
        s_tready       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_MUL: begin
                acc_ctl.mul_en = has_reg;
                state_next     = ST_ACC;
            end
            ST_ACC: begin
                acc_ctl.add_en = has_reg;
                s_tready       = !closes_reg;
                state_next     = closes_reg ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE: begin
                neg_next = weighted_sum[WSUM_W-1];
                if (normalize_reg && (weight_sum != '0)) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    mag_next   = sum_mag >> FRAC_BITS;
                    state_next = ST_FIN;
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    mag_next   = quotient;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = result;
                    m_user_next   = {clip_seen | clamp_hit, weight_sum == '0};
                    acc_ctl.clear = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Capture a new beat
        if (s_accept) begin
            value_next  = s_tdata[VALUE_W-1:0];
            weight_next = s_tdata[S_TDATA_W-1:VALUE_W];
            has_next    = s_tuser;
            closes_next = s_tlast;
            state_next  = ST_MUL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            normalize_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            normalize_reg <= normalize_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        weight_reg <= weight_next;
        has_reg    <= has_next;
        closes_reg <= closes_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== tb/weighted_group_collapse_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the weighted group collapse: directed and random beats, scoreboard.
module weighted_group_collapse_tb;
    import wgc_pkg::*;

    localparam int FRAC          = FRAC_BITS_DEFAULT;
    localparam int SETTLE_CYCLES = 100;    // covers the longest closing beat with margin
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int STALL_LIMIT   = 4000;   // cycles with no beat on either side

    // One expected group result
    typedef struct packed {
        logic [RESULT_W-1:0] value;
        logic                zero_w;
        logic                sat;
    } group_result_t;

    // Predicts group results from accepted sample beats and checks result beats
    class collapse_scoreboard;
        bit                        normalize;
        logic signed [WSUM_W-1:0]  wsum;
        logic [WTSUM_W-1:0]        wtsum;
        bit                        clipped;
        group_result_t             pending_q[$];
        int                        errors;

        function new();
            normalize = 1'b1;
            wsum      = '0;
            wtsum     = '0;
            clipped   = 1'b0;
            errors    = 0;
        endfunction

        function int pending_count();
            return pending_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Accumulate one sample beat and, on a close, queue the group result
        function void note_input(logic [VALUE_W-1:0] val, logic [WEIGHT_W-1:0] wt,
                                 bit has, bit close);
            logic signed [WSUM_W-1:0] prod;
            logic signed [WSUM_W:0]   sum_ext;
            logic [WTSUM_W:0]         wt_ext;
            logic [WSUM_W-1:0]        mag;
            logic [WSUM_W-1:0]        neg_val;
            bit                       neg;
            bit                       sat;
            group_result_t            r;
            if (has) begin
                prod    = longint'($signed(val)) * longint'({32'b0, wt});
                sum_ext = {wsum[WSUM_W-1], wsum} + {prod[WSUM_W-1], prod};
                // Clip the weighted sum at the signed 64-bit limits
                if (sum_ext[WSUM_W] != sum_ext[WSUM_W-1]) begin
                    wsum    = sum_ext[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}}
                                              : {1'b0, {(WSUM_W-1){1'b1}}};
                    clipped = 1'b1;
                end else begin
                    wsum = sum_ext[WSUM_W-1:0];
                end
                wt_ext = {1'b0, wtsum} + {{(WTSUM_W-WEIGHT_W+1){1'b0}}, wt};
                if (wt_ext[WTSUM_W]) begin
                    wtsum   = '1;
                    clipped = 1'b1;
                end else begin
                    wtsum = wt_ext[WTSUM_W-1:0];
                end
            end
            if (!close)
                return;

            // Collapse on magnitudes, truncating toward zero
            neg = wsum[WSUM_W-1];
            mag = neg ? (64'd0 - wsum) : wsum;
            if (normalize && wtsum != 0)
                mag = mag / {{(WSUM_W-WTSUM_W){1'b0}}, wtsum};
            else
                mag = mag >> FRAC;
            sat = clipped;
            if (neg) begin
                if (mag > RES_NEG_MAG) begin
                    mag = RES_NEG_MAG;
                    sat = 1'b1;
                end
                neg_val = 64'd0 - mag;
                r.value = neg_val[RESULT_W-1:0];
            end else begin
                if (mag > RES_POS_MAX) begin
                    mag = RES_POS_MAX;
                    sat = 1'b1;
                end
                r.value = mag[RESULT_W-1:0];
            end
            r.zero_w = (wtsum == 0);
            r.sat    = sat;
            pending_q = {pending_q, r};

            wsum    = '0;
            wtsum   = '0;
            clipped = 1'b0;
        endfunction

        // Compare one result beat with the oldest expectation
        task check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            group_result_t e;
            if (pending_q.size() == 0) begin
                report($sformatf("result %h user %b with nothing expected", data, user));
                return;
            end
            e = pending_q.pop_front();
            if (data !== e.value)
                report($sformatf("group_result %h, expected %h", data, e.value));
            if (user[0] !== e.zero_w)
                report($sformatf("zero_weight %b, expected %b", user[0], e.zero_w));
            if (user[1] !== e.sat)
                report($sformatf("saturated %b, expected %b", user[1], e.sat));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic                  cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [31:0] sample_value, [63:32] sample_weight
    logic                  s_tuser;   // [0] has_sample
    logic                  s_tlast;   // closes_group
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [47:0] group_result
    logic [M_TUSER_W-1:0]  m_tuser;   // [0] zero_weight, [1] saturated

    collapse_scoreboard sb = new();

    int send_idle;
    int recv_idle;
    bit hold_req;
    int hold_left;
    int stall_cycles;

    weighted_group_collapse i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 12 ns clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Drive the result-side ready; a requested hold-off overrides random stalls
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= recv_idle);
        end
    end

    // Check every result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one sample beat, with random idle cycles ahead of it; returns at a falling edge
    task send_beat(logic [VALUE_W-1:0] val, logic [WEIGHT_W-1:0] wt, bit has, bit close);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {wt, val};
        s_tuser  = has;
        s_tlast  = close;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(val, wt, has, close);
        @(negedge aclk);
    endtask

    // Hold the input and wait for every expected result
    task wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending_count() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write normalize while idle
    task write_normalize(bit val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we    = 1'b0;
        sb.normalize = val;
    endtask

    function logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return int'($urandom_range(400000)) - 200000;
            default: return $urandom();
        endcase
    endfunction

    function logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom_range(1, 1 << 17);
            default: return $urandom();
        endcase
    endfunction

    // Send one random group, an empty group or a stray beat; count the beats sent
    task send_group(output int n_beats);
        int kind;
        int len;
        bit late_close;
        kind    = $urandom_range(99);
        n_beats = 0;
        if (kind < 6) begin
            send_beat($urandom(), $urandom(), 1'b0, 1'b1);
            n_beats = 1;
        end else if (kind < 12) begin
            send_beat($urandom(), $urandom(), 1'b0, 1'b0);
            n_beats = 1;
        end else begin
            len        = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
            late_close = ($urandom_range(99) < 8);
            for (int i = 0; i < len; i++)
                send_beat(pick_value(), pick_weight(), 1'b1, (i == len - 1) && !late_close);
            n_beats = len;
            if (late_close) begin
                send_beat($urandom(), $urandom(), 1'b0, 1'b1);
                n_beats++;
            end
        end
    endtask

    // Random groups until a beat count is reached, with optional hold-off and mid-phase drain
    task random_phase(int n_items, bit do_hold, bit do_drain);
        int sent;
        int added;
        bit held;
        bit drained;
        sent    = 0;
        held    = 1'b0;
        drained = 1'b0;
        while (sent < n_items) begin
            send_group(added);
            sent += added;
            if (do_hold && !held && sent >= 50) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (do_drain && !drained && sent >= 100) begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    task set_idle(int snd, int rcv);
        send_idle = snd;
        recv_idle = rcv;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        hold_req  = 1'b0;
        hold_left = 0;
        stall_cycles = 0;
        set_idle(27, 55);
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed, normalize on
        write_normalize(1'b1);
        send_beat('0, '0, 1'b0, 1'b1);                       // empty group
        send_beat(32'h7FFF_FFFF, '1, 1'b1, 1'b1);            // full-scale positive sample
        send_beat(32'h8000_0000, '1, 1'b1, 1'b0);            // negative clip of the sum
        send_beat(32'h8000_0000, '1, 1'b1, 1'b1);
        send_beat(32'h7FFF_FFFF, '1, 1'b1, 1'b0);            // positive clip of the sum
        send_beat(32'h7FFF_FFFF, '1, 1'b1, 1'b1);
        send_beat(32'h0005_0000, '0, 1'b1, 1'b1);            // zero weight sum, no divide
        send_beat('1, '1, 1'b0, 1'b0);                       // neither sample nor close
        send_beat(32'h0003_0000, 32'h0002_0000, 1'b1, 1'b0); // quotient truncates toward zero
        send_beat(32'hFFF9_0000, 32'h0005_0000, 1'b1, 1'b0);
        send_beat('1, '1, 1'b0, 1'b1);                       // close without a sample
        send_beat(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1);

        // Directed, normalize off
        write_normalize(1'b0);
        send_beat('0, '0, 1'b0, 1'b1);
        send_beat(32'h7FFF_FFFF, '1, 1'b1, 1'b1);
        send_beat(32'h8000_0000, '1, 1'b1, 1'b1);
        send_beat(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1); // shift truncates toward zero
        send_beat(32'h0002_0000, '0, 1'b1, 1'b1);            // zero weight still flagged
        send_beat(32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 1'b0);
        send_beat(32'hEDCB_A988, 32'h0000_0001, 1'b1, 1'b1);

        // Random, sender lightly idle and receiver heavily stalled
        write_normalize(1'b1);
        random_phase(200, 1'b1, 1'b0);
        write_normalize(1'b0);
        random_phase(200, 1'b0, 1'b0);

        // Random, the other way round
        set_idle(55, 27);
        write_normalize(1'b1);
        random_phase(200, 1'b0, 1'b1);
        write_normalize(1'b0);
        random_phase(200, 1'b0, 1'b0);

        // Random, no idling
        set_idle(0, 0);
        write_normalize(1'b1);
        random_phase(200, 1'b0, 1'b0);
        write_normalize(1'b0);
        random_phase(200, 1'b0, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wgc_pkg.sv
rtl/wgc_accum.sv
rtl/wgc_divider.sv
rtl/weighted_group_collapse.sv
tb/weighted_group_collapse_tb.sv
